// File: rtl/core/triangle_zplane_slice_defines.svh
// Assertion macros used by the triangle slicer top level.
// Each macro expands to one labeled concurrent assertion on aclk.
`ifndef TRIANGLE_ZPLANE_SLICE_DEFINES_SVH
`define TRIANGLE_ZPLANE_SLICE_DEFINES_SVH

// Property must hold at every edge outside reset.
`define TZS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define TZS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// File: rtl/core/tzs_pkg.sv
// ----------------------------------------------------------------------------
// tzs_pkg
// Shared widths, types and helper functions of the triangle z-plane slicer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tzs_pkg;

    // Internal coordinate width. The fraction bit count does not change any
    // result, since interpolation is scale free.
    localparam int CW = 32;
    // Width of a difference of two coordinates.
    localparam int DW = CW + 1;
    // Width of the exact product of a magnitude and a numerator.
    localparam int PW = 2 * DW;
    // Width of a port coordinate.
    localparam int IOW = 32;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } corner_t;

    // Operands of one interpolation: p0 + sign * trunc(mag * num / den).
    typedef struct packed {
        coord_t          p0;
        logic            neg;
        logic [DW-1:0]   mag;
        logic [DW-1:0]   num;
        logic [DW-1:0]   den;
    } lerp_op_t;

    // Operands of the four interpolations plus the hit flag.
    typedef struct packed {
        lerp_op_t sx;
        lerp_op_t sy;
        lerp_op_t ex;
        lerp_op_t ey;
        logic     hit;
    } slice_op_t;

    // Port word to internal coordinate, as the low CW bits of the word.
    function automatic coord_t to_coord(input logic [IOW-1:0] w);
        return coord_t'(w);
    endfunction

    // Sign-extended difference a - b.
    function automatic diff_t sub_ext(input coord_t a, input coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

    // Build interpolation operands from the two end points and the fraction.
    function automatic lerp_op_t mk_op(input coord_t p0, input coord_t p1,
                                       input diff_t num, input diff_t den);
        lerp_op_t op;
        diff_t    dp;
        dp     = sub_ext(p1, p0);
        op.p0  = p0;
        op.neg = dp[DW-1];
        op.mag = dp[DW-1] ? DW'(-dp) : DW'(dp);
        op.num = num;
        op.den = den;
        return op;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tzs_order.sv
// ----------------------------------------------------------------------------
// tzs_order
// Two pipeline stages: sort the corners by z, then pick the edges and build
// the operands of the four interpolations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tzs_order (
    input  wire logic               aclk,
    input  wire tzs_pkg::corner_t   p0_i,
    input  wire tzs_pkg::corner_t   p1_i,
    input  wire tzs_pkg::corner_t   p2_i,
    input  wire tzs_pkg::coord_t    cut_i,
    input  wire logic               en0_i,
    input  wire logic               en1_i,
    output tzs_pkg::slice_op_t      op_o
);

    tzs_pkg::corner_t   a_next, b_next, c_next;
    tzs_pkg::corner_t   a_reg, b_reg, c_reg;
    tzs_pkg::coord_t    cut_reg;
    logic               flat_next, flat_reg;
    tzs_pkg::slice_op_t op_next, op_reg;

    // Order the corners by z with the tie rules.
    always_comb begin
        flat_next = (p0_i.z == p1_i.z) && (p0_i.z == p2_i.z);
        if ((p0_i.z < p1_i.z) && (p0_i.z < p2_i.z)) begin
            a_next = p0_i;
            b_next = (p1_i.z < p2_i.z) ? p1_i : p2_i;
            c_next = (p1_i.z < p2_i.z) ? p2_i : p1_i;
        end else if (p1_i.z < p2_i.z) begin
            a_next = p1_i;
            b_next = (p0_i.z < p2_i.z) ? p0_i : p2_i;
            c_next = (p0_i.z < p2_i.z) ? p2_i : p0_i;
        end else begin
            a_next = p2_i;
            b_next = (p0_i.z < p1_i.z) ? p0_i : p1_i;
            c_next = (p0_i.z < p1_i.z) ? p1_i : p0_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en0_i) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            cut_reg  <= cut_i;
            flat_reg <= flat_next;
        end
    end

    // Classify the cut and choose the edges. A corner result is an
    // interpolation with a zero span, a miss one from the origin.
    always_comb begin
        tzs_pkg::corner_t s, e, t1, t2;
        logic             miss, at_a, at_c, lower;
        tzs_pkg::diff_t   one;
        one   = tzs_pkg::diff_t'(1);
        at_a  = (cut_reg == a_reg.z);
        at_c  = (cut_reg == c_reg.z);
        lower = (cut_reg < b_reg.z);
        miss  = flat_reg || (cut_reg < a_reg.z) || (cut_reg > c_reg.z);
        s     = at_a ? a_reg : c_reg;
        e     = (cut_reg == b_reg.z) ? b_reg : s;
        t1    = lower ? a_reg : b_reg;
        t2    = lower ? b_reg : c_reg;
        if (miss) begin
            op_next.sx = tzs_pkg::mk_op('0, '0, '0, one);
            op_next.sy = tzs_pkg::mk_op('0, '0, '0, one);
            op_next.ex = tzs_pkg::mk_op('0, '0, '0, one);
            op_next.ey = tzs_pkg::mk_op('0, '0, '0, one);
        end else if (at_a || at_c) begin
            op_next.sx = tzs_pkg::mk_op(s.x, s.x, '0, one);
            op_next.sy = tzs_pkg::mk_op(s.y, s.y, '0, one);
            op_next.ex = tzs_pkg::mk_op(e.x, e.x, '0, one);
            op_next.ey = tzs_pkg::mk_op(e.y, e.y, '0, one);
        end else begin
            op_next.sx = tzs_pkg::mk_op(a_reg.x, c_reg.x,
                tzs_pkg::sub_ext(cut_reg, a_reg.z), tzs_pkg::sub_ext(c_reg.z, a_reg.z));
            op_next.sy = tzs_pkg::mk_op(a_reg.y, c_reg.y,
                tzs_pkg::sub_ext(cut_reg, a_reg.z), tzs_pkg::sub_ext(c_reg.z, a_reg.z));
            op_next.ex = tzs_pkg::mk_op(t1.x, t2.x,
                tzs_pkg::sub_ext(cut_reg, t1.z), tzs_pkg::sub_ext(t2.z, t1.z));
            op_next.ey = tzs_pkg::mk_op(t1.y, t2.y,
                tzs_pkg::sub_ext(cut_reg, t1.z), tzs_pkg::sub_ext(t2.z, t1.z));
        end
        op_next.hit = !miss;
    end

    always_ff @(posedge aclk) begin
        if (en1_i) begin
            op_reg <= op_next;
        end
    end

    assign op_o = op_reg;

endmodule

`default_nettype wire

// File: rtl/core/tzs_lerp.sv
// ----------------------------------------------------------------------------
// tzs_lerp
// Pipelined interpolation: one product stage, a restoring divider with one
// quotient bit per stage, and a final add of the signed quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tzs_lerp (
    input  wire logic                   aclk,
    input  wire tzs_pkg::lerp_op_t      op_i,
    input  wire logic [tzs_pkg::DW+1:0] en_i,
    output tzs_pkg::coord_t             res_o
);

    localparam int DW = tzs_pkg::DW;
    localparam int PW = tzs_pkg::PW;

    // Product stage.
    logic [PW-1:0]    prod_reg;
    tzs_pkg::coord_t  p0_prod_reg;
    logic             neg_prod_reg;
    logic [DW-1:0]    den_prod_reg;

    always_ff @(posedge aclk) begin
        if (en_i[0]) begin
            prod_reg     <= op_i.mag * op_i.num;
            p0_prod_reg  <= op_i.p0;
            neg_prod_reg <= op_i.neg;
            den_prod_reg <= op_i.den;
        end
    end

    // Divider stages. The quotient is below 2^DW, so the top DW product bits
    // are already below the divisor and start as the remainder.
    logic [DW-1:0]    rem_reg [DW+1];
    logic [DW-1:0]    lo_reg  [DW+1];
    logic [DW-1:0]    q_reg   [DW+1];
    logic [DW-1:0]    den_reg [DW+1];
    tzs_pkg::coord_t  p0_reg  [DW+1];
    logic             neg_reg [DW+1];

    always_comb begin
        rem_reg[0] = prod_reg[PW-1:DW];
        lo_reg[0]  = prod_reg[DW-1:0];
        q_reg[0]   = '0;
        den_reg[0] = den_prod_reg;
        p0_reg[0]  = p0_prod_reg;
        neg_reg[0] = neg_prod_reg;
    end

    for (genvar k = 0; k < DW; k++) begin : g_div
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        take;

        // Shift in the next dividend bit and try the subtraction.
        always_comb begin
            trial = {rem_reg[k], lo_reg[k][DW-1]};
            diff  = trial - {1'b0, den_reg[k]};
            take  = (trial >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge aclk) begin
            if (en_i[k+1]) begin
                rem_reg[k+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
                lo_reg[k+1]  <= {lo_reg[k][DW-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][DW-2:0], take};
                den_reg[k+1] <= den_reg[k];
                p0_reg[k+1]  <= p0_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // Apply the quotient with its sign.
    tzs_pkg::coord_t res_next, res_reg;

    always_comb begin
        tzs_pkg::diff_t base;
        tzs_pkg::diff_t sum;
        base     = tzs_pkg::diff_t'(p0_reg[DW]);
        sum      = neg_reg[DW] ? base - tzs_pkg::diff_t'(q_reg[DW])
                               : base + tzs_pkg::diff_t'(q_reg[DW]);
        res_next = sum[tzs_pkg::CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en_i[DW+1]) begin
            res_reg <= res_next;
        end
    end

    assign res_o = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/triangle_zplane_slice.sv
// Depth: DW + 4 = 37 register stages from input transfer to result valid.
// Throughput: one triangle per cycle while the result is taken; every stage
// loads as soon as it is empty or its successor moves, so bubbles close up
// behind a stalled result. The depth is set by the restoring divider, one
// quotient bit per stage.
// Reset: synchronous, active low; clears all stage valid bits, no result pending.
// ----------------------------------------------------------------------------
// triangle_zplane_slice
// Cuts a 3D triangle with the plane z = cut_z and returns the 2D segment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_zplane_slice (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_first_x,
    input  wire logic [31:0] s_first_y,
    input  wire logic [31:0] s_first_z,
    input  wire logic [31:0] s_second_x,
    input  wire logic [31:0] s_second_y,
    input  wire logic [31:0] s_second_z,
    input  wire logic [31:0] s_third_x,
    input  wire logic [31:0] s_third_y,
    input  wire logic [31:0] s_third_z,
    input  wire logic [31:0] s_cut_z,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_start_x,
    output logic [31:0]      m_start_y,
    output logic [31:0]      m_end_x,
    output logic [31:0]      m_end_y,
    output logic             m_hit
);

    `include "triangle_zplane_slice_defines.svh"

    localparam int DW  = tzs_pkg::DW;
    localparam int NST = DW + 4;

    logic [NST-1:0]     v_reg;
    logic [NST-1:0]     en;
    logic               hit_reg [1:NST-1];
    tzs_pkg::corner_t   p0, p1, p2;
    tzs_pkg::slice_op_t op;
    tzs_pkg::coord_t    sx, sy, ex, ey;

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        en[NST-1] = !v_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];

    // Stage valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Hit flag rides beside the interpolation stages.
    always_comb begin
        hit_reg[1] = op.hit;
    end

    for (genvar k = 2; k < NST; k++) begin : g_hit
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                hit_reg[k] <= hit_reg[k-1];
            end
        end
    end

    // Input corners.
    always_comb begin
        p0 = '{x: tzs_pkg::to_coord(s_first_x), y: tzs_pkg::to_coord(s_first_y),
               z: tzs_pkg::to_coord(s_first_z)};
        p1 = '{x: tzs_pkg::to_coord(s_second_x), y: tzs_pkg::to_coord(s_second_y),
               z: tzs_pkg::to_coord(s_second_z)};
        p2 = '{x: tzs_pkg::to_coord(s_third_x), y: tzs_pkg::to_coord(s_third_y),
               z: tzs_pkg::to_coord(s_third_z)};
    end

    tzs_order u_order (
        .aclk  (aclk),
        .p0_i  (p0),
        .p1_i  (p1),
        .p2_i  (p2),
        .cut_i (tzs_pkg::to_coord(s_cut_z)),
        .en0_i (en[0]),
        .en1_i (en[1]),
        .op_o  (op)
    );

    tzs_lerp u_lerp_sx (.aclk(aclk), .op_i(op.sx), .en_i(en[NST-1:2]), .res_o(sx));
    tzs_lerp u_lerp_sy (.aclk(aclk), .op_i(op.sy), .en_i(en[NST-1:2]), .res_o(sy));
    tzs_lerp u_lerp_ex (.aclk(aclk), .op_i(op.ex), .en_i(en[NST-1:2]), .res_o(ex));
    tzs_lerp u_lerp_ey (.aclk(aclk), .op_i(op.ey), .en_i(en[NST-1:2]), .res_o(ey));

    // Result ports, sign extended or truncated to the port width.
    assign m_valid   = v_reg[NST-1];
    assign m_hit     = hit_reg[NST-1];
    assign m_start_x = tzs_pkg::IOW'(sx);
    assign m_start_y = tzs_pkg::IOW'(sy);
    assign m_end_x   = tzs_pkg::IOW'(ex);
    assign m_end_y   = tzs_pkg::IOW'(ey);

    // A miss always reports the origin for both points.
    `TZS_ASSERT(a_miss_zero, (m_valid && !m_hit) |-> (m_start_x == '0 && m_start_y == '0 && m_end_x == '0 && m_end_y == '0), "miss result not zero")
    // Input is refused only while the first stage holds an item.
    `TZS_NEVER(a_ready_empty, !s_ready && !v_reg[0], "input refused with empty first stage")
    // An item in the first stage that may move reaches the second stage.
    `TZS_ASSERT(a_advance, (v_reg[0] && en[1]) |=> v_reg[1], "item lost between stages")

endmodule

`default_nettype wire
